// File: rtl/core/smf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the selective median filter
// Pixel type, configuration register map and register reset values.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int PIXEL_W = 8;
  localparam int DIM_W   = 12;
  localparam int LINE_W  = 2 * PIXEL_W;
  localparam int CFG_IDX_W = 2;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [DIM_W-1:0]   dim_t;

  // one window row in ascending order
  typedef struct packed {
    pixel_t lo;
    pixel_t mid;
    pixel_t hi;
  } tri_t;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

  localparam dim_t   RESET_IMAGE_WIDTH  = 12'd640;
  localparam dim_t   RESET_IMAGE_HEIGHT = 12'd480;
  localparam pixel_t RESET_THRESHOLD    = 8'd20;

endpackage

// File: rtl/core/smf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_ram: generic simple dual-port ram
// One write port, one read port with registered read data held while re is low.
// ----------------------------------------------------------------------------
module smf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/selective_median_3x3_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_median_3x3_filter: switching 3x3 median filter
// Raster pixel stream in, interior pixels out; a centre that stands apart
// from all four neighbour pair averages is replaced by the window median.
//
//   channel  signals                                       direction
//   in       in_valid/in_ready, pixel, start_of_frame       into block
//   out      out_valid/out_ready, filtered_pixel,
//            was_replaced, last_of_frame                   out of block
//   cfg      cfg_write, cfg_index, cfg_data                into block
//
// one word accepted per clock while the output buffer is not full
// both line stores share one ram word {upper, lower}; each word reads it on
// acceptance and writes it back from stage 1, with forwarding between words
// a two-entry output buffer absorbs stalls; in_ready drops only when it is full
// reset clears counters, window, pipeline and loads register defaults; the
// line ram is not cleared
// ----------------------------------------------------------------------------
module selective_median_3x3_filter import smf_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pixel_t               pixel,
  input  logic                 start_of_frame,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pixel_t               filtered_pixel,
  output logic                 was_replaced,
  output logic                 last_of_frame,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

  function automatic pixel_t min2(pixel_t a, pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t max2(pixel_t a, pixel_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic tri_t sort3(pixel_t a, pixel_t b, pixel_t c);
    pixel_t l0;
    pixel_t h0;
    tri_t   t;
    l0    = min2(a, b);
    h0    = max2(a, b);
    t.lo  = min2(l0, c);
    t.hi  = max2(h0, c);
    t.mid = max2(l0, min2(h0, c));
    return t;
  endfunction

  function automatic logic differs(pixel_t a, pixel_t b, pixel_t ctr, pixel_t thr);
    logic [PIXEL_W:0] sum;
    pixel_t           avg;
    pixel_t           d;
    sum = {1'b0, a} + {1'b0, b};
    avg = sum[PIXEL_W:1];
    d   = (avg > ctr) ? avg - ctr : ctr - avg;
    return d > thr;
  endfunction

  // configuration
  dim_t   image_width;
  dim_t   image_height;
  pixel_t threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_IMAGE_WIDTH;
      image_height <= RESET_IMAGE_HEIGHT;
      threshold    <= RESET_THRESHOLD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_THRESHOLD:    threshold    <= cfg_data[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline enable and acceptance
  logic en;
  logic accept;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  // position counters
  logic [CW-1:0]  column_count;
  dim_t           row_count;
  logic [CW-1:0]  col_cur;
  dim_t           row_cur;
  logic [WW-1:0]  w_eff;
  logic [WW-1:0]  col_inc;
  logic [DIM_W:0] row_inc;
  logic           col_wrap;
  logic           row_wrap;
  logic           interior;
  logic           last;

  always_comb begin
    col_cur  = start_of_frame ? '0 : column_count;
    row_cur  = start_of_frame ? '0 : row_count;
    w_eff    = (WW'(image_width) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(image_width);
    col_inc  = WW'(col_cur) + WW'(1);
    row_inc  = {1'b0, row_cur} + (DIM_W + 1)'(1);
    col_wrap = col_inc >= w_eff;
    row_wrap = row_inc >= {1'b0, image_height};
    interior = (row_cur >= DIM_W'(2)) && (WW'(col_cur) >= WW'(2)) &&
               (row_cur < image_height) && (WW'(col_cur) < w_eff);
    last     = (row_inc == {1'b0, image_height}) && (col_inc == w_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_inc[DIM_W-1:0];
      end else begin
        column_count <= col_inc[CW-1:0];
        row_count    <= row_cur;
      end
    end
  end

  // stage 1: line ram read returns, write back {mid, px}
  logic              s1_valid;
  pixel_t            s1_px;
  logic [CW-1:0]     s1_idx;
  logic              s1_interior;
  logic              s1_last;
  logic              s1_fwd;
  logic [LINE_W-1:0] s1_fwd_data;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] s1_line;
  pixel_t            s1_up;
  pixel_t            s1_mid;
  logic              ram_we;

  always_comb begin
    s1_line = s1_fwd ? s1_fwd_data : ram_rdata;
    s1_up   = s1_line[LINE_W-1:PIXEL_W];
    s1_mid  = s1_line[PIXEL_W-1:0];
    ram_we  = en && s1_valid;
  end

  smf_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_idx),
    .wdata({s1_mid, s1_px}),
    .re   (accept),
    .raddr(col_cur),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= pixel;
      s1_idx      <= col_cur;
      s1_interior <= interior;
      s1_last     <= last;
      // the word leaving stage 1 writes this entry at the same edge
      s1_fwd      <= s1_valid && (s1_idx == col_cur);
      s1_fwd_data <= {s1_mid, s1_px};
    end
  end

  // window: rows top to bottom, newest column on the right
  pixel_t win [9];
  logic   v2;
  logic   last2;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= s1_valid && s1_interior;
      if (s1_valid) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= s1_up;
        win[3] <= win[4];
        win[4] <= win[5];
        win[5] <= s1_mid;
        win[6] <= win[7];
        win[7] <= win[8];
        win[8] <= s1_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last2 <= s1_last;
    end
  end

  // stage 2: impulse test and row sort
  logic   rep2;
  tri_t   rows2 [3];
  logic   v3;
  logic   rep3;
  pixel_t ctr3;
  logic   last3;
  tri_t   rows3 [3];

  always_comb begin
    rep2 = differs(win[1], win[7], win[4], threshold) &&
           differs(win[3], win[5], win[4], threshold) &&
           differs(win[0], win[8], win[4], threshold) &&
           differs(win[2], win[6], win[4], threshold);
    for (int i = 0; i < 3; i++) begin
      rows2[i] = sort3(win[3*i], win[3*i+1], win[3*i+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rep3  <= rep2;
      ctr3  <= win[4];
      last3 <= last2;
      for (int i = 0; i < 3; i++) begin
        rows3[i] <= rows2[i];
      end
    end
  end

  // stage 3: max of lows, median of mids, min of highs
  logic   v4;
  logic   rep4;
  pixel_t ctr4;
  logic   last4;
  pixel_t lo_max4;
  pixel_t mid_med4;
  pixel_t hi_min4;
  tri_t   mids3;

  assign mids3 = sort3(rows3[0].mid, rows3[1].mid, rows3[2].mid);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rep4     <= rep3;
      ctr4     <= ctr3;
      last4    <= last3;
      lo_max4  <= max2(max2(rows3[0].lo, rows3[1].lo), rows3[2].lo);
      mid_med4 <= mids3.mid;
      hi_min4  <= min2(min2(rows3[0].hi, rows3[1].hi), rows3[2].hi);
    end
  end

  // stage 4: final median and selection into the output buffer
  tri_t   fin4;
  pixel_t res4;
  logic   push;
  logic   pop;

  always_comb begin
    fin4 = sort3(lo_max4, mid_med4, hi_min4);
    res4 = rep4 ? fin4.mid : ctr4;
    push = en && v4;
    pop  = out_valid && out_ready;
  end

  pixel_t skid_pixel;
  logic   skid_replaced;
  logic   skid_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        filtered_pixel <= skid_pixel;
        was_replaced   <= skid_replaced;
        last_of_frame  <= skid_last;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_pixel    <= res4;
        skid_replaced <= rep4;
        skid_last     <= last4;
      end else begin
        filtered_pixel <= res4;
        was_replaced   <= rep4;
        last_of_frame  <= last4;
      end
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a head entry");

  a_stall_keeps_result: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !out_ready) |=> skid_valid)
    else $error("result dropped while output stalled");

  a_accept_enters_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word missing from stage 1");

  a_full_freezes_pipe: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> ($stable(v4) && $stable(s1_valid)) || $past(pop))
    else $error("pipeline moved while output buffer full");

endmodule

// File: sim/median_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_checker: scoreboard for the selective median filter
// Mirrors the line stores, window and position counters of the filter, tracks
// register writes, predicts each interior word and compares it field by field
// with the words the filter hands out.
// ----------------------------------------------------------------------------
module median_filter_checker import smf_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  pixel_t               pixel,
  input  logic                 start_of_frame,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  pixel_t               filtered_pixel,
  input  logic                 was_replaced,
  input  logic                 last_of_frame,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   pending,
  output int                   mismatches
);

  typedef struct packed {
    pixel_t value;
    logic   replaced;
    logic   last;
  } filtered_t;

  pixel_t      upper_mem [MAX_WIDTH];
  pixel_t      lower_mem [MAX_WIDTH];
  pixel_t      win [9];
  int unsigned col_pos;
  int unsigned row_pos;
  dim_t        width_reg;
  dim_t        height_reg;
  pixel_t      thr_reg;
  filtered_t   filtered_q [$];
  int          fail_total = 0;

  function automatic bit stands_apart(pixel_t a, pixel_t b, pixel_t centre);
    int unsigned avg;
    int unsigned gap;
    avg = (int'(a) + int'(b)) >> 1;
    gap = (avg > centre) ? avg - centre : centre - avg;
    return gap > thr_reg;
  endfunction

  function automatic pixel_t window_median();
    pixel_t s [9];
    pixel_t t;
    s = win;
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 8 - i; k++) begin
        if (s[k] > s[k+1]) begin
          t      = s[k];
          s[k]   = s[k+1];
          s[k+1] = t;
        end
      end
    end
    return s[4];
  endfunction

  task automatic note_failure(input string msg);
    fail_total++;
    if (fail_total <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic clear_model();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_mem[i] = '0;
      lower_mem[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = RESET_IMAGE_WIDTH;
    height_reg = RESET_IMAGE_HEIGHT;
    thr_reg    = RESET_THRESHOLD;
    filtered_q.delete();
  endtask

  task automatic predict_word(input pixel_t px, input logic sof);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned idx;
    pixel_t      up;
    pixel_t      mid;
    logic        hit;
    filtered_t   res;
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = height_reg;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    c   = col_pos;
    r   = row_pos;
    idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    up  = upper_mem[idx];
    mid = lower_mem[idx];
    upper_mem[idx] = mid;
    lower_mem[idx] = px;
    // window rows top to bottom, newest column on the right
    win[0] = win[1]; win[1] = win[2]; win[2] = up;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = px;
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      hit = stands_apart(win[1], win[7], win[4]) && stands_apart(win[3], win[5], win[4]) &&
            stands_apart(win[0], win[8], win[4]) && stands_apart(win[2], win[6], win[4]);
      res.value    = hit ? window_median() : win[4];
      res.replaced = hit;
      res.last     = (r + 1 == h) && (c + 1 == w);
      filtered_q.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_word();
    filtered_t want;
    if (filtered_q.size() == 0) begin
      note_failure($sformatf(
        "unexpected word: filtered_pixel %0d was_replaced %0b last_of_frame %0b",
        filtered_pixel, was_replaced, last_of_frame));
    end else begin
      want = filtered_q.pop_front();
      if (filtered_pixel !== want.value)
        note_failure($sformatf("filtered_pixel: expected %0d, got %0d",
                               want.value, filtered_pixel));
      if (was_replaced !== want.replaced)
        note_failure($sformatf("was_replaced: expected %0b, got %0b",
                               want.replaced, was_replaced));
      if (last_of_frame !== want.last)
        note_failure($sformatf("last_of_frame: expected %0b, got %0b",
                               want.last, last_of_frame));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          REG_THRESHOLD:    thr_reg = cfg_data[PIXEL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_word();
      if (in_valid && in_ready) predict_word(pixel, start_of_frame);
    end
    pending    <= filtered_q.size();
    mismatches <= fail_total;
  end

endmodule

// File: sim/selective_median_3x3_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_median_3x3_filter_test: stimulus and verdict for the median filter
// Streams directed impulse windows, then frames of random, smooth-with-impulse
// and salt-and-pepper content over many frame sizes and thresholds, with
// random gaps and back-pressure; a checker module scores every word.
// ----------------------------------------------------------------------------
module selective_median_3x3_filter_test;
  import smf_pkg::*;

  localparam int LINE_MAX    = 2048;
  localparam int ITEM_TARGET = 1350;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pixel_t               pixel = '0;
  logic                 start_of_frame = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pixel_t               filtered_pixel;
  logic                 was_replaced;
  logic                 last_of_frame;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  int                   pending;
  int                   mismatches;
  bit                   quiet = 1'b0;
  int                   words_sent = 0;

  selective_median_3x3_filter #(.MAX_WIDTH(LINE_MAX)) dut (.*);

  median_filter_checker #(.MAX_WIDTH(LINE_MAX)) scoreboard (.*);

  always #1 clk = ~clk;

  always @(posedge clk) out_ready <= quiet || ($urandom_range(0, 99) >= 12);

  task automatic send_word(input pixel_t px, input logic sof);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    pixel          <= px;
    start_of_frame <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // registers change only once the filter has gone quiet
  task automatic settle_and_configure(input logic [11:0] w, input logic [11:0] h,
                                      input logic [11:0] thr);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // 3x3 frame, raster index i in byte i
  task automatic send_window(input logic [71:0] px9);
    for (int i = 0; i < 9; i++) send_word(px9[8*i +: 8], i == 0);
  endtask

  function automatic pixel_t next_pixel(input int mode, input int base);
    int r;
    int v;
    r = $urandom_range(0, 99);
    case (mode)
      1, 2: begin
        if (r < 8) return (r % 2) ? 8'd255 : 8'd0;
        if (r < 12) return PIXEL_W'($urandom_range(0, 255));
        v = base + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIXEL_W'(v);
      end
      3: return (r < 50) ? 8'd255 : 8'd0;
      default: return PIXEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // sof opens most frames; some frames follow on by position wrap alone,
  // and now and then a frame restarts midway
  task automatic run_phase(input int unsigned w_cfg, input int unsigned h_cfg, input int n_words,
                           input int mode, input bit sof_first);
    int unsigned w_eff;
    int unsigned frame_len;
    int unsigned pos;
    int          base;
    logic        sof;
    w_eff     = (w_cfg > LINE_MAX) ? LINE_MAX : w_cfg;
    frame_len = w_eff * h_cfg;
    base      = $urandom_range(0, 255);
    pos       = 0;
    for (int i = 0; i < n_words; i++) begin
      if (frame_len != 0 && pos >= frame_len) pos = 0;
      sof = 1'b0;
      if (i == 0) begin
        sof = sof_first;
      end else if (pos == 0) begin
        sof = ($urandom_range(0, 9) < 7);
      end else if ($urandom_range(0, 149) == 0) begin
        sof = 1'b1;
        pos = 0;
      end
      send_word(next_pixel(mode, base), sof);
      pos++;
    end
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int          n;
    int          guard;
    logic [11:0] thr;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // unmapped register index must be ignored
    cfg_write <= 1'b1;
    cfg_index <= REG_UNMAPPED;
    cfg_data  <= DIM_W'($urandom_range(0, 4095));
    @(posedge clk);
    cfg_write <= 1'b0;

    // impulse on flat ground, inverted impulse, and a centre matched vertically
    settle_and_configure(12'd3, 12'd3, 12'd0);
    send_window({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
    send_window({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
    send_window({8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0});

    // sizes too small to hold an interior pixel
    settle_and_configure(12'd0, 12'd5, 12'd10);
    run_phase(0, 5, 20, 0, 1'b1);
    settle_and_configure(12'd2, 12'd4, 12'd10);
    run_phase(2, 4, 20, 0, 1'b1);
    settle_and_configure(12'd5, 12'd2, 12'd10);
    run_phase(5, 2, 20, 0, 1'b1);
    settle_and_configure(12'd4, 12'd0, 12'd10);
    run_phase(4, 0, 20, 0, 1'b1);
    settle_and_configure(12'd1, 12'd1, 12'd10);
    run_phase(1, 1, 10, 0, 1'b1);

    // stop mid-frame past the new limits, then shrink both without a new frame
    settle_and_configure(12'd20, 12'd10, 12'd30);
    run_phase(20, 10, 20 * 7 + 15, 1, 1'b1);
    settle_and_configure(12'd10, 12'd5, 12'hF28);
    run_phase(10, 5, 120, 1, 1'b0);

    // widest line setting, clamped to the line store depth; first row only
    settle_and_configure(12'd4095, 12'd3, 12'd25);
    run_phase(4095, 3, 60, 1, 1'b1);

    // a long stretch with no idling at all
    settle_and_configure(12'd24, 12'd8, 12'd25);
    quiet = 1'b1;
    run_phase(24, 8, 24 * 8, 1, 1'b1);
    quiet = 1'b0;

    // tallest frame on the narrowest line, its first rows
    settle_and_configure(12'd3, 12'd4095, 12'd255);
    run_phase(3, 4095, 3 * 60, 2, 1'b1);

    while (words_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       w = 3;
        1, 2:    w = $urandom_range(25, 80);
        default: w = $urandom_range(3, 24);
      endcase
      h = $urandom_range(3, 10);
      case ($urandom_range(0, 5))
        0:       thr = 12'd0;
        1:       thr = 12'd255;
        2:       thr = 12'($urandom_range(0, 4095));
        default: thr = 12'($urandom_range(10, 60));
      endcase
      n = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
      if (n > ITEM_TARGET - words_sent) n = ITEM_TARGET - words_sent;
      settle_and_configure(12'(w), 12'(h), thr);
      run_phase(w, h, n, $urandom_range(0, 3), 1'b1);
    end

    in_valid <= 1'b0;
    guard = 0;
    repeat (2) @(posedge clk);
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("selective_median_3x3_filter_test: PASS");
    end else begin
      $display("selective_median_3x3_filter_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("selective_median_3x3_filter_test: FAIL");
    $finish;
  end

endmodule
